// ----- design/pflfq_pkg.sv -----
package pflfq_pkg;

	// Sizes of the pool and of the queue set.
	localparam int POOL_SIZE  = 32;
	localparam int NUM_QUEUES = 8;

	// Field widths of one item; these fix the pool at 32 entries and 8 queues.
	localparam int ENTRY_W  = 5;
	localparam int QUEUE_W  = 3;
	localparam int ACTION_W = 3;

	typedef logic [ENTRY_W-1:0] entry_t;
	typedef logic [QUEUE_W-1:0] qid_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ALLOC     = 3'd0,
		ACT_FREE      = 3'd1,
		ACT_INSERT    = 3'd2,
		ACT_REM_OLD   = 3'd3,
		ACT_REM_ENTRY = 3'd4,
		ACT_PEEK      = 3'd5
	} action_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		qid_t                queue_id;
		entry_t              entry;
	} cmd_t;

	typedef struct packed {
		entry_t entry_out;
		logic   ok;
		logic   queue_empty;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_INS2,
		ST_WALK
	} state_t;

	// Micro-operations the controller issues to the datapath.
	typedef enum logic [3:0] {
		DP_NONE,
		DP_CAPTURE,
		DP_ALLOC,
		DP_FREE,
		DP_INS_FIRST,
		DP_INS_LINK,
		DP_INS_TAIL,
		DP_WALK_INIT,
		DP_WALK_STEP,
		DP_UNLINK_LAST,
		DP_UNLINK_MID
	} dp_op_t;

	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_FREE_HEAD,
		SEL_TAIL,
		SEL_TARGET
	} res_sel_t;

	typedef struct packed {
		dp_op_t   op;
		logic     fin;
		logic     fin_ok;
		res_sel_t sel;
	} dp_cmd_t;

	typedef struct packed {
		action_t act;
		logic    free_ne;
		logic    q_ne;
		logic    cur_hit;
		logic    prev_hit;
		logic    cur_tail;
		logic    steps_last;
	} dp_stat_t;

endpackage

// ----- design/pflfq_dp.sv -----
module pflfq_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  pflfq_pkg::cmd_t    cmd,
	input  pflfq_pkg::dp_cmd_t ctl,
	output pflfq_pkg::dp_stat_t stat,
	output logic               done,
	output pflfq_pkg::rsp_t    rsp
);
	import pflfq_pkg::*;

	entry_t  link_q [POOL_SIZE];
	logic    end_q  [POOL_SIZE];
	entry_t  free_head_q;
	logic    free_ne_q;
	entry_t  tail_q [NUM_QUEUES];
	logic    qne_q  [NUM_QUEUES];

	action_t act_q;
	qid_t    qid_q;
	entry_t  entry_q;
	entry_t  prev_q;
	entry_t  cur_q;
	entry_t  target_q;
	entry_t  steps_q;

	rsp_t    rsp_q;
	logic    done_q;

	entry_t  tail_cur;
	entry_t  rd_addr;
	entry_t  rd_data;
	logic    wr_en;
	entry_t  wr_addr;
	entry_t  wr_data;
	logic    end_wr;
	logic    end_data;
	logic    qempty_nx;
	entry_t  res_val;

	assign tail_cur = tail_q[qid_q];
	assign rd_data  = link_q[rd_addr];

	always_comb begin
		unique case (ctl.op) inside
			DP_ALLOC:                    rd_addr = free_head_q;
			[DP_INS_LINK:DP_INS_LINK],
			[DP_WALK_INIT:DP_WALK_INIT]: rd_addr = tail_cur;
			DP_UNLINK_MID:               rd_addr = target_q;
			default:                     rd_addr = cur_q;
		endcase
	end

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = entry_q;
		wr_data  = rd_data;
		end_wr   = 1'b0;
		end_data = 1'b0;
		unique case (ctl.op)
			DP_ALLOC: begin
				wr_en    = 1'b1;
				wr_addr  = free_head_q;
				wr_data  = '0;
				end_wr   = 1'b1;
				end_data = 1'b1;
			end
			DP_FREE: begin
				wr_en    = 1'b1;
				wr_data  = free_head_q;
				end_wr   = 1'b1;
				end_data = !free_ne_q;
			end
			DP_INS_FIRST: begin
				wr_en   = 1'b1;
				wr_data = entry_q;
			end
			DP_INS_LINK: begin
				wr_en = 1'b1;
			end
			DP_INS_TAIL: begin
				wr_en   = 1'b1;
				wr_addr = tail_cur;
				wr_data = entry_q;
			end
			DP_UNLINK_MID: begin
				wr_en   = 1'b1;
				wr_addr = prev_q;
			end
			default: begin
			end
		endcase
	end

	// Link memory and end marks reset to one chained free list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POOL_SIZE; i++) begin
				link_q[i] <= ENTRY_W'((i + 1) % POOL_SIZE);
				end_q[i]  <= (i == POOL_SIZE - 1);
			end
		end else begin
			if (wr_en)
				link_q[wr_addr] <= wr_data;
			if (end_wr)
				end_q[wr_addr] <= end_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			free_ne_q   <= 1'b1;
			for (int i = 0; i < NUM_QUEUES; i++)
				qne_q[i] <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.fin;
			case (ctl.op)
				DP_ALLOC: begin
					free_head_q <= rd_data;
					free_ne_q   <= !end_q[free_head_q];
				end
				DP_FREE: begin
					free_head_q <= entry_q;
					free_ne_q   <= 1'b1;
				end
				DP_INS_FIRST:   qne_q[qid_q] <= 1'b1;
				DP_UNLINK_LAST: qne_q[qid_q] <= 1'b0;
				default: begin
				end
			endcase
		end
	end

	// Tail registers hold no meaning until the queue is first filled.
	always_ff @(posedge clk) begin
		if (ctl.op == DP_INS_FIRST)
			tail_q[qid_q] <= entry_q;
		else if (ctl.op == DP_UNLINK_MID && target_q == tail_cur)
			tail_q[qid_q] <= prev_q;
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			DP_CAPTURE: begin
				act_q   <= action_t'(cmd.action);
				qid_q   <= cmd.queue_id;
				entry_q <= cmd.entry;
			end
			DP_WALK_INIT: begin
				prev_q   <= tail_cur;
				cur_q    <= rd_data;
				steps_q  <= '0;
				target_q <= (act_q == ACT_REM_OLD) ? tail_cur : entry_q;
			end
			DP_WALK_STEP: begin
				prev_q  <= cur_q;
				cur_q   <= rd_data;
				steps_q <= steps_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		unique case (ctl.sel)
			SEL_FREE_HEAD: res_val = free_head_q;
			SEL_TAIL:      res_val = tail_cur;
			SEL_TARGET:    res_val = target_q;
			default:       res_val = '0;
		endcase
		if (ctl.op == DP_UNLINK_LAST)
			qempty_nx = 1'b1;
		else if (ctl.op == DP_INS_FIRST)
			qempty_nx = 1'b0;
		else
			qempty_nx = !qne_q[qid_q];
	end

	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			rsp_q.entry_out   <= ctl.fin_ok ? res_val : '0;
			rsp_q.ok          <= ctl.fin_ok;
			rsp_q.queue_empty <= qempty_nx;
		end
	end

	assign stat.act        = act_q;
	assign stat.free_ne    = free_ne_q;
	assign stat.q_ne       = qne_q[qid_q];
	assign stat.cur_hit    = (cur_q == target_q);
	assign stat.prev_hit   = (prev_q == target_q);
	assign stat.cur_tail   = (cur_q == tail_cur);
	assign stat.steps_last = (steps_q == ENTRY_W'(POOL_SIZE - 1));

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ----- design/pflfq_ctrl.sv -----
module pflfq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  pflfq_pkg::dp_stat_t stat,
	output logic                busy,
	output pflfq_pkg::dp_cmd_t  ctl
);
	import pflfq_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start)
					state_nx = ST_EXEC;
			end
			ST_EXEC: begin
				state_nx = ST_IDLE;
				if (stat.act == ACT_INSERT && stat.q_ne)
					state_nx = ST_INS2;
				else if ((stat.act == ACT_REM_OLD || stat.act == ACT_REM_ENTRY) && stat.q_ne)
					state_nx = ST_WALK;
			end
			ST_INS2: state_nx = ST_IDLE;
			ST_WALK: begin
				if (stat.cur_hit || stat.cur_tail || stat.steps_last)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Datapath commands.
	always_comb begin
		ctl.op     = DP_NONE;
		ctl.fin    = 1'b0;
		ctl.fin_ok = 1'b0;
		ctl.sel    = SEL_ZERO;
		unique case (state_q)
			ST_IDLE: begin
				if (start)
					ctl.op = DP_CAPTURE;
			end
			ST_EXEC: begin
				case (stat.act) inside
					ACT_ALLOC: begin
						ctl.fin = 1'b1;
						if (stat.free_ne) begin
							ctl.op     = DP_ALLOC;
							ctl.fin_ok = 1'b1;
							ctl.sel    = SEL_FREE_HEAD;
						end
					end
					ACT_FREE: begin
						ctl.op     = DP_FREE;
						ctl.fin    = 1'b1;
						ctl.fin_ok = 1'b1;
					end
					ACT_INSERT: begin
						if (stat.q_ne) begin
							ctl.op = DP_INS_LINK;
						end else begin
							ctl.op     = DP_INS_FIRST;
							ctl.fin    = 1'b1;
							ctl.fin_ok = 1'b1;
						end
					end
					[ACT_REM_OLD:ACT_REM_ENTRY]: begin
						if (stat.q_ne)
							ctl.op = DP_WALK_INIT;
						else
							ctl.fin = 1'b1;
					end
					ACT_PEEK: begin
						ctl.fin    = 1'b1;
						ctl.fin_ok = stat.q_ne;
						ctl.sel    = SEL_TAIL;
					end
					default: ctl.fin = 1'b1;
				endcase
			end
			ST_INS2: begin
				ctl.op     = DP_INS_TAIL;
				ctl.fin    = 1'b1;
				ctl.fin_ok = 1'b1;
			end
			ST_WALK: begin
				if (stat.cur_hit) begin
					ctl.op     = stat.prev_hit ? DP_UNLINK_LAST : DP_UNLINK_MID;
					ctl.fin    = 1'b1;
					ctl.fin_ok = 1'b1;
					ctl.sel    = SEL_TARGET;
				end else if (stat.cur_tail || stat.steps_last) begin
					ctl.fin = 1'b1;
				end else begin
					ctl.op = DP_WALK_STEP;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ----- design/pooled_free_list_and_fifo_queues_core.sv -----
// Allocate, free, peek, insert into an empty queue and any action that fails on an
// empty pool or queue finish in the execute state; insert into a non-empty queue adds
// a tail step; the two remove actions walk the ring, one entry per step, up to the pool size.
// Throughput: a new item is taken in the cycle its predecessor's done strobe shows.
// Reset chains every pool entry into the free list and empties every queue.
// The receiver cannot stall: each result is valid for the single done cycle only.
module pooled_free_list_and_fifo_queues_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  pflfq_pkg::cmd_t cmd,
	output logic            done,
	output pflfq_pkg::rsp_t rsp
);
	import pflfq_pkg::*;

	// The controller sequences one item at a time and issues one datapath
	// micro-operation per cycle. The datapath owns the link memory, which has
	// a single read and a single write address each cycle; the ring walk that
	// finds a predecessor for the remove actions therefore visits one entry per
	// step, bounded by the pool size.
	dp_cmd_t  ctl;
	dp_stat_t stat;

	pflfq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.ctl    (ctl)
	);

	// Results are registered inside the datapath, so the strobe and the
	// payload leave the block from flops.
	pflfq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctl    (ctl),
		.stat   (stat),
		.done   (done),
		.rsp    (rsp)
	);

	// A result can only appear once the controller has returned to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while an item is still in progress");

	// An accepted item always occupies the block in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not start work");

	// Two results never come back to back: each needs its own item.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobes in consecutive cycles");

	// A failed action reports entry zero.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.ok) |-> (rsp.entry_out == '0))
		else $error("failed action reported a nonzero entry");

endmodule
